// File: rtl/ideq_pkg.sv
// Package with the types, codes and sizes of the indexed double-ended queue.
package ideq_pkg;

  localparam int DEPTH = 16;
  localparam int HANDLE_BITS = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [3:0] K_PUSH_FRONT    = 4'd0;
  localparam logic [3:0] K_PUSH_BACK     = 4'd1;
  localparam logic [3:0] K_POP_FRONT     = 4'd2;
  localparam logic [3:0] K_POP_BACK      = 4'd3;
  localparam logic [3:0] K_PEEK_FRONT    = 4'd4;
  localparam logic [3:0] K_PEEK_BACK     = 4'd5;
  localparam logic [3:0] K_PEEK_AT       = 4'd6;
  localparam logic [3:0] K_REMOVE_HANDLE = 4'd7;
  localparam logic [3:0] K_REMOVE_AT     = 4'd8;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [3:0]             kind;
    logic [HANDLE_BITS-1:0] handle;
    logic [3:0]             position;
  } req_t;

  typedef struct packed {
    logic [1:0]             status;
    logic [HANDLE_BITS-1:0] handle_out;
    logic [4:0]             occupancy;
    logic                   is_empty;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_SHIFT_DN,
    S_SHIFT_UP,
    S_PUT_FRONT
  } state_t;

endpackage

// File: rtl/indexed_double_ended_queue.sv
// Top level of the indexed double-ended queue: slot memory and its sequencer.
//
//   Channel   Signals            Direction  Transfer
//   request   start, busy, req   in         start high and busy low at a clock edge
//   result    done, rsp          out        done high for one cycle, always taken
//
// Back pushes, front pushes to an empty queue and refused requests are answered from
// idle; peeks read their entry in the fetch state. Pops and removals fetch the entry,
// then shift each later entry toward the front. A front push to a nonempty queue shifts
// every entry up, then writes the front slot; a removal by handle scans entries until
// one matches. The slot memory has one registered read port. Reset clears the count at
// once, with no clearing pass. The receiver cannot stall; busy holds requests off.
module indexed_double_ended_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  ideq_pkg::req_t req,
  output logic          done,
  output ideq_pkg::rsp_t rsp
);
  import ideq_pkg::*;

  logic [HANDLE_BITS-1:0] mem [DEPTH];
  logic [HANDLE_BITS-1:0] rdata;
  logic [IDX_W-1:0]       raddr;
  logic [IDX_W-1:0]       waddr;
  logic [HANDLE_BITS-1:0] wdata;
  logic                   we;

  state_t                 state, state_next;
  logic [CNT_W-1:0]       count, count_next;
  logic [CNT_W-1:0]       ptr, ptr_next;
  logic [HANDLE_BITS-1:0] hold, hold_next;
  logic [3:0]             kind_r;
  logic [HANDLE_BITS-1:0] handle_r;
  logic                   accept;
  logic                   emit;
  rsp_t                   rsp_next;
  logic [1:0]             st;
  logic [HANDLE_BITS-1:0] hout;

  logic [CNT_W-1:0]       ptr_p1, ptr_m1, ptr_m2, cnt_m1, req_pos;
  logic [CNT_W:0]         ptr_p2;
  logic                   is_rm, hit;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign ptr_p1  = ptr + CNT_W'(1);
  assign ptr_m1  = ptr - CNT_W'(1);
  assign ptr_m2  = ptr - CNT_W'(2);
  assign ptr_p2  = {1'b0, ptr} + (CNT_W+1)'(2);
  assign cnt_m1  = count - CNT_W'(1);
  assign req_pos = CNT_W'(req.position);

  assign is_rm = (kind_r == K_POP_FRONT) || (kind_r == K_POP_BACK) ||
                 (kind_r == K_REMOVE_HANDLE) || (kind_r == K_REMOVE_AT);
  assign hit   = (kind_r != K_REMOVE_HANDLE) || (rdata == handle_r);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= emit;
    end
  end

  always_ff @(posedge clk) begin
    ptr  <= ptr_next;
    hold <= hold_next;
    if (accept) begin
      kind_r   <= req.kind;
      handle_r <= req.handle;
    end
    if (emit) begin
      rsp <= rsp_next;
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    ptr_next   = ptr;
    hold_next  = hold;
    we         = 1'b0;
    waddr      = ptr[IDX_W-1:0];
    wdata      = rdata;
    raddr      = ptr[IDX_W-1:0];
    emit       = 1'b0;
    st         = ST_MISS;
    hout       = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (req.kind)
            K_PUSH_FRONT, K_PUSH_BACK: begin
              if (count == CNT_W'(DEPTH)) begin
                emit = 1'b1;
                st   = ST_FULL;
              end else if (req.kind == K_PUSH_BACK || count == '0) begin
                we         = 1'b1;
                waddr      = (req.kind == K_PUSH_BACK) ? count[IDX_W-1:0] : '0;
                wdata      = req.handle;
                count_next = count + CNT_W'(1);
                emit       = 1'b1;
                st         = ST_OK;
              end else begin
                raddr      = cnt_m1[IDX_W-1:0];
                ptr_next   = count;
                state_next = S_SHIFT_UP;
              end
            end
            K_POP_FRONT, K_PEEK_FRONT, K_REMOVE_HANDLE: begin
              if (count == '0) begin
                emit = 1'b1;
              end else begin
                raddr      = '0;
                ptr_next   = '0;
                state_next = S_FETCH;
              end
            end
            K_POP_BACK, K_PEEK_BACK: begin
              if (count == '0) begin
                emit = 1'b1;
              end else begin
                raddr      = cnt_m1[IDX_W-1:0];
                ptr_next   = cnt_m1;
                state_next = S_FETCH;
              end
            end
            K_PEEK_AT, K_REMOVE_AT: begin
              if (req_pos >= count) begin
                emit = 1'b1;
              end else begin
                raddr      = req_pos[IDX_W-1:0];
                ptr_next   = req_pos;
                state_next = S_FETCH;
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      S_FETCH: begin
        if (hit) begin
          if (!is_rm) begin
            emit       = 1'b1;
            st         = ST_OK;
            hout       = rdata;
            state_next = S_IDLE;
          end else begin
            hold_next = rdata;
            if (ptr_p1 < count) begin
              raddr      = ptr_p1[IDX_W-1:0];
              state_next = S_SHIFT_DN;
            end else begin
              count_next = cnt_m1;
              emit       = 1'b1;
              st         = ST_OK;
              hout       = rdata;
              state_next = S_IDLE;
            end
          end
        end else if (ptr_p1 < count) begin
          ptr_next = ptr_p1;
          raddr    = ptr_p1[IDX_W-1:0];
        end else begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SHIFT_DN: begin
        we       = 1'b1;
        ptr_next = ptr_p1;
        if (ptr_p2 < {1'b0, count}) begin
          raddr = ptr_p2[IDX_W-1:0];
        end else begin
          count_next = cnt_m1;
          emit       = 1'b1;
          st         = ST_OK;
          hout       = hold;
          state_next = S_IDLE;
        end
      end
      S_SHIFT_UP: begin
        we       = 1'b1;
        ptr_next = ptr_m1;
        raddr    = ptr_m2[IDX_W-1:0];
        if (ptr == CNT_W'(1)) begin
          state_next = S_PUT_FRONT;
        end
      end
      S_PUT_FRONT: begin
        we         = 1'b1;
        waddr      = '0;
        wdata      = handle_r;
        count_next = count + CNT_W'(1);
        emit       = 1'b1;
        st         = ST_OK;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    rsp_next.status     = st;
    rsp_next.handle_out = hout;
    rsp_next.occupancy  = 5'(count_next);
    rsp_next.is_empty   = (count_next == '0);
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count exceeds the queue depth");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    done && rsp.status == ST_FULL |-> rsp.occupancy == 5'(DEPTH))
    else $error("full status reported on a queue that is not full");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    done && rsp.status != ST_OK |-> rsp.handle_out == '0)
    else $error("refused request returned a nonzero handle");

  a_shift_dn_end: assert property (@(posedge clk) disable iff (rst)
    state == S_SHIFT_DN |=> state == S_SHIFT_DN || (state == S_IDLE && done))
    else $error("removal shift ended without a result transfer");

endmodule

// File: bench/tb_indexed_double_ended_queue.sv
// Self-checking testbench for the indexed double-ended queue of process handles.
`timescale 1ns / 100ps

module tb_indexed_double_ended_queue;
  import ideq_pkg::*;

  typedef struct packed {
    req_t item;
    logic settle;
  } planned_req_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  req_t req;
  logic done;
  rsp_t rsp;

  planned_req_t planned[$];
  rsp_t         outcomes_due[$];

  logic [HANDLE_BITS-1:0] ready_slots [DEPTH];
  int                     ready_count;

  bit handed_off;
  int transfers_in;
  int planned_total;
  int mismatches;
  int burst_left;
  int gap_left;

  indexed_double_ended_queue uut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic rsp_t apply_request(input req_t r);
    rsp_t res;
    int   i;
    int   hit;
    res.status = ST_MISS;
    res.handle_out = '0;
    hit = -1;
    case (r.kind)
      K_PUSH_FRONT, K_PUSH_BACK: begin
        if (ready_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          if (r.kind == K_PUSH_FRONT) begin
            for (i = ready_count; i > 0; i--) ready_slots[i] = ready_slots[i-1];
            ready_slots[0] = r.handle;
          end else begin
            ready_slots[ready_count] = r.handle;
          end
          ready_count++;
          res.status = ST_OK;
        end
      end
      K_POP_FRONT: if (ready_count > 0) hit = 0;
      K_POP_BACK: if (ready_count > 0) hit = ready_count - 1;
      K_PEEK_FRONT: begin
        if (ready_count > 0) begin
          res.handle_out = ready_slots[0];
          res.status = ST_OK;
        end
      end
      K_PEEK_BACK: begin
        if (ready_count > 0) begin
          res.handle_out = ready_slots[ready_count-1];
          res.status = ST_OK;
        end
      end
      K_PEEK_AT: begin
        if (r.position < ready_count) begin
          res.handle_out = ready_slots[r.position];
          res.status = ST_OK;
        end
      end
      K_REMOVE_HANDLE: begin
        for (i = 0; i < ready_count; i++)
          if (hit < 0 && ready_slots[i] == r.handle) hit = i;
      end
      K_REMOVE_AT: if (r.position < ready_count) hit = r.position;
      default: ;
    endcase
    if (hit >= 0) begin
      res.handle_out = ready_slots[hit];
      res.status = ST_OK;
      for (i = hit; i + 1 < ready_count; i++) ready_slots[i] = ready_slots[i+1];
      ready_count--;
    end
    res.occupancy = ready_count[4:0];
    res.is_empty = (ready_count == 0);
    return res;
  endfunction

  task automatic plan(input logic [3:0] k, input logic [HANDLE_BITS-1:0] h,
                      input logic [3:0] p, input bit settle);
    planned_req_t op;
    op.item.kind = k;
    op.item.handle = h;
    op.item.position = p;
    op.settle = settle;
    planned.push_back(op);
  endtask

  task automatic report_mismatch(input rsp_t want, input rsp_t got, input bit orphan);
    if (mismatches < 10) begin
      if (orphan) begin
        $display("%0t: result with none pending: status %0d handle %h occ %0d empty %b",
                 $realtime, got.status, got.handle_out, got.occupancy, got.is_empty);
      end else begin
        $write("%0t: mismatch: expected status %0d handle %h occ %0d empty %b, ",
               $realtime, want.status, want.handle_out, want.occupancy, want.is_empty);
        $display("got status %0d handle %h occ %0d empty %b",
                 got.status, got.handle_out, got.occupancy, got.is_empty);
      end
    end
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    rsp_t want;
    if (rst) begin
      handed_off = 1'b0;
    end else begin
      if (done) begin
        if (outcomes_due.size() == 0) begin
          report_mismatch(rsp, rsp, 1'b1);
        end else begin
          want = outcomes_due.pop_front();
          if (rsp.status !== want.status || rsp.handle_out !== want.handle_out ||
              rsp.occupancy !== want.occupancy || rsp.is_empty !== want.is_empty)
            report_mismatch(want, rsp, 1'b0);
        end
      end
      handed_off = start && !busy;
      if (handed_off) begin
        outcomes_due.push_back(apply_request(req));
        transfers_in++;
      end
    end
  end

  always @(negedge clk) begin : feed
    planned_req_t nxt;
    if (!rst && (!start || handed_off)) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (planned.size() != 0 &&
                   !(planned[0].settle && outcomes_due.size() != 0)) begin
        nxt = planned.pop_front();
        req <= nxt.item;
        start <= 1'b1;
        if (burst_left == 0) burst_left = $urandom_range(1, 40);
        burst_left--;
        if (burst_left == 0) gap_left = $urandom_range(1, 9);
      end else begin
        start <= 1'b0;
      end
    end
  end

  initial begin
    int n;
    int phase_len;
    int push_pct;
    int r;
    int j;
    logic [3:0] k;
    logic [3:0] p;
    logic [HANDLE_BITS-1:0] h;
    logic [HANDLE_BITS-1:0] handle_pool [8];

    rst = 1'b1;
    start = 1'b0;
    req = '0;
    ready_count = 0;
    handed_off = 1'b0;
    transfers_in = 0;
    mismatches = 0;
    burst_left = 0;
    gap_left = 0;

    plan(K_POP_FRONT, 16'h0000, 4'd0, 1'b0);
    plan(K_POP_BACK, 16'h0000, 4'd0, 1'b0);
    plan(K_PEEK_FRONT, 16'h0000, 4'd0, 1'b0);
    plan(K_PEEK_BACK, 16'h0000, 4'd0, 1'b0);
    plan(K_PEEK_AT, 16'h0000, 4'd0, 1'b0);
    plan(K_REMOVE_HANDLE, 16'h0000, 4'd0, 1'b0);
    plan(K_REMOVE_AT, 16'h0000, 4'd0, 1'b0);
    plan(4'd9, 16'hFFFF, 4'd15, 1'b0);
    plan(K_PUSH_BACK, 16'h0000, 4'd0, 1'b0);
    plan(K_PUSH_FRONT, 16'hFFFF, 4'd15, 1'b0);
    plan(K_PUSH_BACK, 16'hFFFF, 4'd0, 1'b0);
    plan(K_PEEK_FRONT, 16'h0000, 4'd0, 1'b0);
    plan(K_PEEK_BACK, 16'h0000, 4'd0, 1'b0);
    plan(K_PEEK_AT, 16'h0000, 4'd2, 1'b0);
    plan(K_PEEK_AT, 16'h0000, 4'd3, 1'b0);
    plan(K_PEEK_AT, 16'h0000, 4'd15, 1'b0);
    plan(K_REMOVE_HANDLE, 16'hFFFF, 4'd0, 1'b0);
    plan(K_REMOVE_HANDLE, 16'h1234, 4'd0, 1'b0);
    plan(K_REMOVE_AT, 16'h0000, 4'd5, 1'b0);
    plan(K_PUSH_FRONT, 16'h8000, 4'd0, 1'b0);
    plan(K_REMOVE_AT, 16'h0000, 4'd1, 1'b0);
    plan(4'd15, 16'h0000, 4'd0, 1'b0);
    plan(K_POP_BACK, 16'h0000, 4'd0, 1'b0);
    plan(K_POP_FRONT, 16'h0000, 4'd0, 1'b0);

    handle_pool[0] = 16'h0000;
    handle_pool[1] = 16'hFFFF;
    n = 0;
    while (n < 1600) begin
      for (j = 2; j < 8; j++) handle_pool[j] = HANDLE_BITS'($urandom);
      case ($urandom_range(0, 2))
        0: push_pct = 73;
        1: push_pct = 23;
        default: push_pct = 48;
      endcase
      phase_len = $urandom_range(20, 60);
      for (j = 0; j < phase_len; j++) begin
        r = $urandom_range(0, 99);
        if (r < 3) k = 4'($urandom_range(9, 15));
        else if (r < push_pct) k = 4'($urandom_range(0, 1));
        else k = 4'($urandom_range(2, 8));
        h = $urandom_range(0, 1) ? handle_pool[3'($urandom_range(0, 7))]
                                 : HANDLE_BITS'($urandom);
        p = $urandom_range(0, 1) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
        plan(k, h, p, (j == 0) && (n == 0 || $urandom_range(0, 3) == 0));
        n++;
      end
    end
    planned_total = planned.size();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (transfers_in != planned_total) @(posedge clk);
    while (outcomes_due.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);

    if (mismatches == 0 && outcomes_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
